// ----- sv/gbm_pkg.sv -----
// Shared constants, types and command structures for the Goertzel bin magnitude block.
package gbm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 17;
    localparam int SINE_W      = 16;
    localparam int STATE_W     = 48;
    localparam int MAG_W       = 41;
    localparam int COEF_FRAC   = 14;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = COEF_W;

    localparam int HALF_W      = STATE_W / 2;
    localparam int OPD_W       = 25;
    localparam int PROD_W      = 2 * OPD_W;
    localparam int ACC_W       = 4 * OPD_W;
    localparam int MP_W        = COEF_W + STATE_W;
    localparam int RND_W       = 52;

    localparam int ROOT_W      = ACC_W / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int SQRT_OUT_W  = ROOT_W + 1;
    localparam int SQRT_ITER   = ROOT_W;
    localparam int SQRT_CNT_W  = $clog2(SQRT_ITER);

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_HALF = 2'd1,
        SH_OPD  = 2'd2,
        SH_OPD2 = 2'd3
    } mac_shift_t;

    typedef struct packed {
        logic             en;
        logic             clear;
        logic [OPD_W-1:0] a;
        logic [OPD_W-1:0] b;
        mac_shift_t       shift;
    } mac_cmd_t;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] radicand;
    } sqrt_req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS = 1'b0,
        CFG_SIN = 1'b1
    } cfg_index_t;

endpackage

// ----- sv/gbm_mac.sv -----
// Shared 25x25 unsigned multiply-accumulate unit with selectable partial-product weight.
module gbm_mac (
    input  logic                           clk,
    input  gbm_pkg::mac_cmd_t              cmd,
    output logic [gbm_pkg::ACC_W-1:0]      acc
);

    logic [gbm_pkg::PROD_W-1:0] prod;
    logic [gbm_pkg::ACC_W-1:0]  term;
    logic [gbm_pkg::ACC_W-1:0]  acc_reg;
    logic [gbm_pkg::ACC_W-1:0]  acc_next;

    always_comb
    begin
        prod = gbm_pkg::PROD_W'(cmd.a) * gbm_pkg::PROD_W'(cmd.b);
        case (cmd.shift)
            gbm_pkg::SH_NONE: term = gbm_pkg::ACC_W'(prod);
            gbm_pkg::SH_HALF: term = gbm_pkg::ACC_W'(prod) << gbm_pkg::HALF_W;
            gbm_pkg::SH_OPD:  term = gbm_pkg::ACC_W'(prod) << gbm_pkg::OPD_W;
            gbm_pkg::SH_OPD2: term = gbm_pkg::ACC_W'(prod) << (2 * gbm_pkg::OPD_W);
            default:          term = '0;
        endcase
        if (cmd.en)
        begin
            acc_next = (cmd.clear ? '0 : acc_reg) + term;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ----- sv/gbm_sqrt.sv -----
// Digit-by-digit square root, one result bit per cycle, rounded to nearest.
module gbm_sqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gbm_pkg::sqrt_req_t                 req,
    output logic                               done,
    output logic [gbm_pkg::SQRT_OUT_W-1:0]     root
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [gbm_pkg::SQRT_CNT_W-1:0]    cnt_reg;
    logic [gbm_pkg::ACC_W-1:0]         rad_reg;
    logic [gbm_pkg::REM_W-1:0]         rem_reg;
    logic [gbm_pkg::ROOT_W-1:0]        root_reg;

    logic [gbm_pkg::REM_W-1:0]         rem_sh;
    logic [gbm_pkg::REM_W-1:0]         trial;
    logic [gbm_pkg::REM_W-1:0]         rem_next;
    logic [gbm_pkg::ROOT_W-1:0]        root_next;

    always_comb
    begin
        rem_sh = {rem_reg[gbm_pkg::REM_W-3:0], rad_reg[gbm_pkg::ACC_W-1 -: 2]};
        trial  = gbm_pkg::REM_W'({root_reg, 2'b01});
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[gbm_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_reg[gbm_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= gbm_pkg::SQRT_CNT_W'(gbm_pkg::SQRT_ITER - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[gbm_pkg::ACC_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    // remainder is v - r^2; round up when it exceeds r
    assign root = gbm_pkg::SQRT_OUT_W'(root_reg)
                + gbm_pkg::SQRT_OUT_W'(rem_reg > gbm_pkg::REM_W'(root_reg));
    assign done = done_reg;

endmodule

// ----- sv/goertzel_bin_magnitude.sv -----
// Top level: sequencer, recursion state and result register of the Goertzel bin detector.
//
//  port group                  dir   width            transfer when
//  sample, last_sample         in    16 + 1           in_valid && in_ready
//  bin_magnitude               out   41               out_valid && out_ready
//  cfg_index, cfg_data         in    1 + 17           cfg_valid && cfg_ready (always ready)
//
//  Ordinary sample: accept, two MAC passes, round, update, then ready for the next transfer.
//  Last sample: the magnitude becomes valid once the square root is through, and the next
//  transfer is taken after that; the 50-step square root dominates.
//  All products go through the one 25x25 MAC unit.
//  A magnitude still waiting in the output register holds the next one back, in_ready low.
//  rst_n clears the coefficients, the recursion and all control state.
module goertzel_bin_magnitude (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [gbm_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                 last_sample,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    output logic [gbm_pkg::MAG_W-1:0]            bin_magnitude,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [gbm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gbm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b00000001,
        ST_MUL       = 8'b00000010,
        ST_RND       = 8'b00000100,
        ST_UPD       = 8'b00001000,
        ST_SQR       = 8'b00010000,
        ST_SQRT_GO   = 8'b00100000,
        ST_SQRT_WAIT = 8'b01000000,
        ST_EMIT      = 8'b10000000
    } state_t;

    typedef enum logic [1:0] {
        JOB_P  = 2'd0,
        JOB_RE = 2'd1,
        JOB_IM = 2'd2
    } job_t;

    state_t state_reg;
    job_t   job_reg;
    logic [2:0] step_reg;

    logic signed [gbm_pkg::COEF_W-1:0]   c_reg;
    logic signed [gbm_pkg::SINE_W-1:0]   sin_reg;
    logic signed [gbm_pkg::SAMPLE_W-1:0] x_reg;
    logic                                last_reg;
    logic signed [gbm_pkg::STATE_W-1:0]  s1_reg;
    logic signed [gbm_pkg::STATE_W-1:0]  s2_reg;
    logic signed [gbm_pkg::RND_W-1:0]    rnd_reg;
    logic signed [gbm_pkg::RND_W-1:0]    re_reg;
    logic signed [gbm_pkg::RND_W-1:0]    im_reg;
    logic                                out_valid_reg;
    logic [gbm_pkg::MAG_W-1:0]           mag_reg;

    gbm_pkg::mac_cmd_t                   mac_cmd;
    logic [gbm_pkg::ACC_W-1:0]           acc;
    gbm_pkg::sqrt_req_t                  sqrt_req;
    logic                                sqrt_done;
    logic [gbm_pkg::SQRT_OUT_W-1:0]      sqrt_root;

    logic [gbm_pkg::COEF_W-1:0]          c_mag;
    logic [gbm_pkg::SINE_W-1:0]          sin_mag;
    logic [gbm_pkg::STATE_W-1:0]         s1_mag;
    logic                                mul_neg;
    logic [gbm_pkg::MP_W-1:0]            rnd_sum;
    logic [gbm_pkg::MP_W-1:0]            rnd_shift;
    logic signed [gbm_pkg::RND_W-1:0]    rnd_mag;
    logic signed [gbm_pkg::RND_W-1:0]    rnd_val;
    logic signed [gbm_pkg::RND_W+1:0]    upd_sum;
    logic                                upd_ovf;
    logic signed [gbm_pkg::STATE_W-1:0]  upd_sat;
    logic signed [gbm_pkg::RND_W-1:0]    sq_val;
    logic [gbm_pkg::RND_W-1:0]           sq_abs;
    logic [gbm_pkg::OPD_W-1:0]           sq_lo;
    logic [gbm_pkg::OPD_W-1:0]           sq_hi;
    logic [gbm_pkg::MAG_W-1:0]           mag_sat;
    logic                                emit_load;

    gbm_mac u_mac (
        .clk (clk),
        .cmd (mac_cmd),
        .acc (acc)
    );

    gbm_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    always_comb
    begin
        c_mag   = c_reg[gbm_pkg::COEF_W-1] ? gbm_pkg::COEF_W'(-c_reg) : c_reg;
        sin_mag = sin_reg[gbm_pkg::SINE_W-1] ? gbm_pkg::SINE_W'(-sin_reg) : sin_reg;
        s1_mag  = s1_reg[gbm_pkg::STATE_W-1] ? gbm_pkg::STATE_W'(-s1_reg) : s1_reg;
        mul_neg = (job_reg == JOB_IM) ? (sin_reg[gbm_pkg::SINE_W-1] ^ s1_reg[gbm_pkg::STATE_W-1])
                                      : (c_reg[gbm_pkg::COEF_W-1] ^ s1_reg[gbm_pkg::STATE_W-1]);

        // round half away from zero on the magnitude
        if (job_reg == JOB_RE)
        begin
            rnd_sum   = acc[gbm_pkg::MP_W-1:0] + (gbm_pkg::MP_W'(1) << gbm_pkg::COEF_FRAC);
            rnd_shift = rnd_sum >> (gbm_pkg::COEF_FRAC + 1);
        end
        else
        begin
            rnd_sum   = acc[gbm_pkg::MP_W-1:0] + (gbm_pkg::MP_W'(1) << (gbm_pkg::COEF_FRAC - 1));
            rnd_shift = rnd_sum >> gbm_pkg::COEF_FRAC;
        end
        rnd_mag = rnd_shift[gbm_pkg::RND_W-1:0];
        rnd_val = mul_neg ? -rnd_mag : rnd_mag;

        upd_sum = (gbm_pkg::RND_W+2)'(x_reg) + (gbm_pkg::RND_W+2)'(rnd_reg)
                - (gbm_pkg::RND_W+2)'(s2_reg);
        upd_ovf = !((&upd_sum[gbm_pkg::RND_W+1:gbm_pkg::STATE_W-1])
                 || !(|upd_sum[gbm_pkg::RND_W+1:gbm_pkg::STATE_W-1]));
        if (upd_ovf)
        begin
            upd_sat = upd_sum[gbm_pkg::RND_W+1]
                    ? {1'b1, {(gbm_pkg::STATE_W-1){1'b0}}}
                    : {1'b0, {(gbm_pkg::STATE_W-1){1'b1}}};
        end
        else
        begin
            upd_sat = upd_sum[gbm_pkg::STATE_W-1:0];
        end

        sq_val = step_reg[2] ? im_reg : re_reg;
        sq_abs = sq_val[gbm_pkg::RND_W-1] ? gbm_pkg::RND_W'(-sq_val) : sq_val;
        sq_lo  = sq_abs[gbm_pkg::OPD_W-1:0];
        sq_hi  = sq_abs[2*gbm_pkg::OPD_W-1:gbm_pkg::OPD_W];

        mac_cmd       = '0;
        mac_cmd.clear = (step_reg == '0);
        if (state_reg == ST_MUL)
        begin
            mac_cmd.en    = 1'b1;
            mac_cmd.a     = (job_reg == JOB_IM) ? gbm_pkg::OPD_W'(sin_mag)
                                                : gbm_pkg::OPD_W'(c_mag);
            mac_cmd.b     = step_reg[0]
                          ? gbm_pkg::OPD_W'(s1_mag[gbm_pkg::STATE_W-1:gbm_pkg::HALF_W])
                          : gbm_pkg::OPD_W'(s1_mag[gbm_pkg::HALF_W-1:0]);
            mac_cmd.shift = step_reg[0] ? gbm_pkg::SH_HALF : gbm_pkg::SH_NONE;
        end
        else if (state_reg == ST_SQR)
        begin
            mac_cmd.en = 1'b1;
            case (step_reg[1:0])
                2'd0:
                begin
                    mac_cmd.a     = sq_lo;
                    mac_cmd.b     = sq_lo;
                    mac_cmd.shift = gbm_pkg::SH_NONE;
                end
                2'd1:
                begin
                    mac_cmd.a     = sq_lo;
                    mac_cmd.b     = sq_hi;
                    mac_cmd.shift = gbm_pkg::SH_OPD;
                end
                2'd2:
                begin
                    mac_cmd.a     = sq_hi;
                    mac_cmd.b     = sq_lo;
                    mac_cmd.shift = gbm_pkg::SH_OPD;
                end
                default:
                begin
                    mac_cmd.a     = sq_hi;
                    mac_cmd.b     = sq_hi;
                    mac_cmd.shift = gbm_pkg::SH_OPD2;
                end
            endcase
        end

        sqrt_req.start    = (state_reg == ST_SQRT_GO);
        sqrt_req.radicand = acc;

        if (|sqrt_root[gbm_pkg::SQRT_OUT_W-1:gbm_pkg::MAG_W])
        begin
            mag_sat = '1;
        end
        else
        begin
            mag_sat = sqrt_root[gbm_pkg::MAG_W-1:0];
        end

        emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg   <= '0;
            sin_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gbm_pkg::CFG_COS: c_reg   <= cfg_data[gbm_pkg::COEF_W-1:0];
                gbm_pkg::CFG_SIN: sin_reg <= cfg_data[gbm_pkg::SINE_W-1:0];
                default:          c_reg   <= c_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_P;
            step_reg      <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        job_reg   <= JOB_P;
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (step_reg[0])
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_RND;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_RND:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    case (job_reg)
                        JOB_P:
                        begin
                            s1_reg <= upd_sat;
                            s2_reg <= s1_reg;
                            if (last_reg)
                            begin
                                job_reg   <= JOB_RE;
                                state_reg <= ST_MUL;
                            end
                            else
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        JOB_RE:
                        begin
                            job_reg   <= JOB_IM;
                            state_reg <= ST_MUL;
                        end
                        default:
                        begin
                            step_reg  <= '0;
                            state_reg <= ST_SQR;
                        end
                    endcase
                end
                ST_SQR:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (&step_reg)
                    begin
                        state_reg <= ST_SQRT_GO;
                    end
                end
                ST_SQRT_GO:
                begin
                    state_reg <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        s1_reg    <= '0;
                        s2_reg    <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            x_reg    <= sample;
            last_reg <= last_sample;
        end
        if (state_reg == ST_RND)
        begin
            rnd_reg <= rnd_val;
        end
        if (state_reg == ST_UPD && job_reg == JOB_RE)
        begin
            re_reg <= rnd_reg - gbm_pkg::RND_W'(s2_reg);
        end
        if (state_reg == ST_UPD && job_reg == JOB_IM)
        begin
            im_reg <= rnd_reg;
        end
        if (emit_load)
        begin
            mag_reg <= mag_sat;
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign bin_magnitude = mag_reg;
    assign cfg_ready     = 1'b1;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_MUL && step_reg == '0 && job_reg == JOB_P)
        else $error("transfer did not start the recursion product");

    a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == ST_SQRT_WAIT)
        else $error("square root finished outside its wait state");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> out_valid_reg && s1_reg == '0 && s2_reg == '0 && state_reg == ST_IDLE)
        else $error("result load did not clear the recursion");

    a_s1_writes: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(s1_reg) |-> $past(state_reg) == ST_UPD || $past(state_reg) == ST_EMIT)
        else $error("recursion state changed outside update or emit");

endmodule
